/* rtl/fir_pkg.sv */
// fir_pkg: shared constants for the direct-form fir filter
// field widths, opcode codes and parameter defaults; no dependencies
`default_nettype none

package fir_pkg;

    // parameter defaults
    localparam int NTAPS_DEF       = 32;
    localparam int SAMPLE_BITS_DEF = 16;

    // fixed field widths
    localparam int OUT_W  = 37;
    localparam int TAPS_W = 6;
    localparam int IDX_W  = 5;

    // tap count after reset
    localparam logic [TAPS_W-1:0] TAPS_RESET = 6'd32;

    // item opcodes
    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

endpackage

`default_nettype wire

/* rtl/fir_filter.sv */
// fir_filter: direct-form fir filter with a loadable coefficient table
// one shared multiply-accumulate walks the taps; uses fir_pkg
`default_nettype none

//  channel   ports                                   direction
//  input     s_valid s_ready s_opcode s_value         in (ready out)
//            s_coef_index
//  result    m_valid m_ready m_filtered               out (ready in)
//  config    cfg_wr_en cfg_wr_data (taps_in_use)      in
//
//  a sample beat walks min(taps_in_use, NTAPS) taps from accept to the result
//  register, and the next input beat is taken once the result is pushed; the
//  single multiply-accumulate handles one tap per cycle behind a registered table
//  read and a product register. a coefficient load gives no result. reset
//  clears the tap valid bits, so both tables read as zero at once. s_ready is
//  low while a sample is worked on, and a finished result waits in the output
//  register until m_ready, holding the sequencer only then.

module fir_filter #(
    parameter int NTAPS       = fir_pkg::NTAPS_DEF,
    parameter int SAMPLE_BITS = fir_pkg::SAMPLE_BITS_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // configuration
    input  wire                              cfg_wr_en,
    input  wire  [fir_pkg::TAPS_W-1:0]       cfg_wr_data,
    // input channel
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire                              s_opcode,
    input  wire  signed [SAMPLE_BITS-1:0]    s_value,
    input  wire  [fir_pkg::IDX_W-1:0]        s_coef_index,
    // result channel
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic signed [fir_pkg::OUT_W-1:0] m_filtered
);

    localparam int PTR_W  = (NTAPS > 1) ? $clog2(NTAPS) : 1;
    localparam int CNT_W  = $clog2(NTAPS + 1);
    localparam int PROD_W = 2 * SAMPLE_BITS;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_PUSH  = 2'd3;

    logic [1:0]                     state_reg, state_next;
    logic [fir_pkg::TAPS_W-1:0]     taps_reg;
    logic [PTR_W-1:0]               newest_reg, newest_next;
    logic [PTR_W-1:0]               k_reg, k_next;
    logic [PTR_W-1:0]               hptr_reg, hptr_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [NTAPS-1:0]               hist_vld_reg, coef_vld_reg;

    logic signed [SAMPLE_BITS-1:0]  hist_mem [NTAPS];
    logic signed [SAMPLE_BITS-1:0]  coef_mem [NTAPS];

    logic signed [SAMPLE_BITS-1:0]  hist_rd_reg, coef_rd_reg;
    logic                           hist_ok_reg, coef_ok_reg;
    logic                           rd_vld_reg, prod_vld_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [fir_pkg::OUT_W-1:0] acc_reg, acc_next;

    logic                           m_valid_reg, m_valid_next;
    logic signed [fir_pkg::OUT_W-1:0] m_filtered_reg;

    logic                           s_beat, smp_beat, load_beat, load_hit;
    logic                           issue, last_tap, push;
    logic [PTR_W-1:0]               wr_ptr;
    logic [PTR_W-1:0]               load_ptr;
    logic [CNT_W-1:0]               clipped;
    logic signed [SAMPLE_BITS-1:0]  mul_a, mul_b;

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_filtered = m_filtered_reg;

    // beat decode
    assign s_beat    = s_valid && s_ready;
    assign smp_beat  = s_beat && (s_opcode == fir_pkg::OP_FILTER);
    assign load_beat = s_beat && (s_opcode == fir_pkg::OP_LOAD);
    assign load_hit  = load_beat && (32'(s_coef_index) < NTAPS);
    assign load_ptr  = PTR_W'(s_coef_index);

    // next history slot, wrapping at the table end
    assign wr_ptr = (newest_reg == PTR_W'(NTAPS - 1)) ? '0 : newest_reg + PTR_W'(1);

    // tap count clipped to the table size
    assign clipped = (32'(taps_reg) > NTAPS) ? CNT_W'(NTAPS) : CNT_W'(taps_reg);

    assign issue    = (state_reg == ST_RUN);
    assign last_tap = (CNT_W'(k_reg) + CNT_W'(1)) == count_reg;
    assign push     = (state_reg == ST_PUSH) && (!m_valid_reg || m_ready);

    // sequencer
    always_comb begin
        state_next  = state_reg;
        newest_next = newest_reg;
        k_next      = k_reg;
        hptr_next   = hptr_reg;
        count_next  = count_reg;
        acc_next    = acc_reg;
        if (prod_vld_reg) begin
            acc_next = acc_reg + fir_pkg::OUT_W'(prod_reg);
        end
        case (state_reg)
            ST_IDLE: begin
                if (smp_beat) begin
                    newest_next = wr_ptr;
                    hptr_next   = wr_ptr;
                    k_next      = '0;
                    count_next  = clipped;
                    acc_next    = '0;
                    state_next  = (clipped == '0) ? ST_DRAIN : ST_RUN;
                end
            end
            ST_RUN: begin
                k_next    = k_reg + PTR_W'(1);
                hptr_next = (hptr_reg == '0) ? PTR_W'(NTAPS - 1) : hptr_reg - PTR_W'(1);
                if (last_tap) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!rd_vld_reg && !prod_vld_reg) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (push) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            taps_reg     <= fir_pkg::TAPS_RESET;
            newest_reg   <= '0;
            k_reg        <= '0;
            hptr_reg     <= '0;
            count_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            hist_vld_reg <= '0;
            coef_vld_reg <= '0;
        end else begin
            state_reg    <= state_next;
            newest_reg   <= newest_next;
            k_reg        <= k_next;
            hptr_reg     <= hptr_next;
            count_reg    <= count_next;
            rd_vld_reg   <= issue;
            prod_vld_reg <= rd_vld_reg;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                taps_reg <= cfg_wr_data;
            end
            if (smp_beat) begin
                hist_vld_reg[wr_ptr] <= 1'b1;
            end
            if (load_hit) begin
                coef_vld_reg[load_ptr] <= 1'b1;
            end
        end
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (push) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (push) begin
            m_filtered_reg <= acc_reg;
        end
    end

    // history and coefficient tables, registered reads
    always_ff @(posedge aclk) begin
        if (smp_beat) begin
            hist_mem[wr_ptr] <= s_value;
        end
        if (load_hit) begin
            coef_mem[load_ptr] <= s_value;
        end
        hist_rd_reg <= hist_mem[hptr_reg];
        coef_rd_reg <= coef_mem[k_reg];
        hist_ok_reg <= hist_vld_reg[hptr_reg];
        coef_ok_reg <= coef_vld_reg[k_reg];
    end

    // shared multiplier, entries never written read as zero
    assign mul_a = hist_ok_reg ? hist_rd_reg : '0;
    assign mul_b = coef_ok_reg ? coef_rd_reg : '0;

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

`ifndef SYNTHESIS
    // a sample beat holds off the next input beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        smp_beat |=> !s_ready)
        else $error("input taken right after a sample beat");

    // tap counter stays below the clipped count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (CNT_W'(k_reg) < count_reg))
        else $error("tap counter ran past the tap count");

    // products only arrive while the sum is being formed
    assert property (@(posedge aclk) disable iff (!aresetn)
        prod_vld_reg |-> (state_reg == ST_DRAIN || state_reg == ST_RUN))
        else $error("product arrived outside a sample");
`endif

endmodule

`default_nettype wire
